[sv/sedm_pkg.sv]
package sedm_pkg;

  // Register file layout
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int DELAY_W    = 17;
  localparam int GAIN_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEREO = 2'd2;

  localparam logic [DELAY_W-1:0] DELAY_RST = 17'd5000;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd32768;
  localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'd65536;

  // Gain fraction bits
  localparam int FRAC_BITS = 16;

  // Pipeline control handed to each channel's mixer
  typedef struct packed {
    logic adv;     // pipeline advances this cycle
    logic active;  // echo tap is valid for the item in stage 1
  } sedm_mix_ctl_t;

endpackage

[sv/sedm_in_if.sv]
interface sedm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

[sv/sedm_out_if.sv]
interface sedm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[sv/sedm_cfg_if.sv]
interface sedm_cfg_if
  import sedm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/sedm_mix.sv]
module sedm_mix
  import sedm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  sedm_mix_ctl_t                 ctl,
  input  logic [GAIN_W-1:0]             gain,
  input  logic signed [SAMPLE_BITS-1:0] cur,
  input  logic signed [SAMPLE_BITS-1:0] past,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int SW = SAMPLE_BITS + 18;

  localparam logic signed [SW-1:0] SAT_HI =
    {{(SW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO =
    {{(SW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SW-1:0]          prod_nxt;
  logic signed [SW-1:0]          prod_r;
  logic signed [SAMPLE_BITS-1:0] cur_r;
  logic                          active_r;
  logic signed [SW-1:0]          sum;
  logic signed [SW-1:0]          quo;
  logic                          frac_nz;
  logic signed [SW-1:0]          quo_adj;
  logic signed [SAMPLE_BITS-1:0] y_nxt;
  logic signed [SAMPLE_BITS-1:0] y_r;

  // gain is unsigned: give it a zero sign bit
  assign prod_nxt = $signed({1'b0, gain}) * past;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r   <= prod_nxt;
      cur_r    <= cur;
      active_r <= ctl.active;
    end
  end

  // cur * 2^16 + g * past, then divide by 2^16 truncating toward zero
  assign sum     = $signed({{2{cur_r[SAMPLE_BITS-1]}}, cur_r, {FRAC_BITS{1'b0}}}) + prod_r;
  assign quo     = sum >>> FRAC_BITS;
  assign frac_nz = (sum[FRAC_BITS-1:0] != '0);
  assign quo_adj = quo + $signed({{(SW-1){1'b0}}, sum[SW-1] & frac_nz});

  always_comb begin
    if (!active_r) begin
      y_nxt = cur_r;
    end else if (quo_adj > SAT_HI) begin
      y_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (quo_adj < SAT_LO) begin
      y_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      y_nxt = quo_adj[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

[sv/stereo_echo_delay_mixer.sv]
// Channel   Dir   Handshake      Payload
// in_ch     in    valid/ready    left_sample, right_sample (SAMPLE_BITS, signed)
// out_ch    out   valid/ready    left_out, right_out (SAMPLE_BITS, signed)
// cfg_ch    in    valid/ready    index (2 bits), data (17 bits); ready always high
//
// One item per cycle while out_ch is not stalled; out_ch.valid comes from the out_valid
// register, which follows the stage 1 and stage 2 valid registers.
// The rate is set by the single read and single write port of each delay memory,
// both used once in the accept cycle.
// Reset (rst_n low, synchronous) clears the pipeline valids, the write pointer,
// the fill count and the config registers; the delay memories are not cleared.
// A stalled out_ch freezes the whole pipeline; in_ch.ready drops in the same cycle.
module stereo_echo_delay_mixer
  import sedm_pkg::*;
#(
  parameter int MAX_DELAY   = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  sedm_in_if.sink       in_ch,
  sedm_out_if.source    out_ch,
  sedm_cfg_if.sink      cfg_ch
);

  // AW indexes the memory, CW holds MAX_DELAY itself
  localparam int AW = $clog2(MAX_DELAY);
  localparam int CW = $clog2(MAX_DELAY + 1);
  localparam int EW = (CW > DELAY_W) ? CW : DELAY_W;
  localparam int RW = CW + 1;

  localparam logic [EW-1:0] MAX_E   = EW'(MAX_DELAY);
  localparam logic [RW-1:0] MAX_R   = RW'(MAX_DELAY);
  localparam logic [AW-1:0] LAST_WP = AW'(MAX_DELAY - 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DELAY_W-1:0] delay_r;
  logic [GAIN_W-1:0]  gain_r;
  logic               stereo_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r  <= DELAY_RST;
      gain_r   <= GAIN_RST;
      stereo_r <= 1'b1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DELAY:  delay_r  <= cfg_ch.data[DELAY_W-1:0];
        REG_GAIN:   gain_r   <= cfg_ch.data[GAIN_W-1:0];
        REG_STEREO: stereo_r <= cfg_ch.data[0];
        default:    ;  // unknown index: dropped
      endcase
    end
  end

  // Effective delay: zero means one, clamp to memory depth
  logic [EW-1:0]     delay_e;
  logic [CW-1:0]     d_eff;
  logic [GAIN_W-1:0] gain_eff;

  always_comb begin
    delay_e = (delay_r == '0) ? EW'(1) : EW'(delay_r);
    if (delay_e > MAX_E) begin
      delay_e = MAX_E;
    end
    d_eff = delay_e[CW-1:0];
  end

  assign gain_eff = (gain_r > GAIN_ONE) ? GAIN_ONE : gain_r;

  // ---------------------------------------------------------------------
  // Pipeline control: accept -> stage 1 (memory read) -> stage 2 (product)
  // -> output register (sum, round, saturate)
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv, accept;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  // ---------------------------------------------------------------------
  // Write pointer, fill count, read address
  // ---------------------------------------------------------------------
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] fill_r, fill_clamp, fill_nxt;
  logic          active;
  logic [RW-1:0] rd_diff, rd_wrap;
  logic [AW-1:0] rd_addr;

  always_comb begin
    fill_clamp = (fill_r > d_eff) ? d_eff : fill_r;
    active     = (fill_clamp == d_eff);
    fill_nxt   = active ? fill_clamp : fill_clamp + CW'(1);
    wp_nxt     = (wp_r == LAST_WP) ? '0 : wp_r + AW'(1);
    // Tap D entries behind the write pointer, modulo depth
    rd_diff    = RW'(wp_r) - RW'(d_eff);
    rd_wrap    = rd_diff[RW-1] ? rd_diff + MAX_R : rd_diff;
    rd_addr    = rd_wrap[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (accept) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Delay memories: read old data and write new sample in the accept cycle.
  // A delay of the full depth hits the same entry; the read returns the old
  // value, which is the one wanted.
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] left_mem  [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] right_mem [MAX_DELAY];
  logic signed [SAMPLE_BITS-1:0] past_l_r, past_r_r;
  logic signed [SAMPLE_BITS-1:0] cur_l_r, cur_r_r;
  logic signed [SAMPLE_BITS-1:0] xr;
  logic                          s1_active_r;

  // Mono: right input is ignored and zero goes into the right memory
  assign xr = stereo_r ? in_ch.right_sample : '0;

  always_ff @(posedge clk) begin
    if (accept) begin
      past_l_r        <= left_mem[rd_addr];
      past_r_r        <= right_mem[rd_addr];
      left_mem[wp_r]  <= in_ch.left_sample;
      right_mem[wp_r] <= xr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cur_l_r     <= in_ch.left_sample;
      cur_r_r     <= xr;
      s1_active_r <= active;
    end
  end

  // ---------------------------------------------------------------------
  // Per-channel mix
  // ---------------------------------------------------------------------
  sedm_mix_ctl_t                 mix_ctl;
  logic signed [SAMPLE_BITS-1:0] y_l, y_r;

  assign mix_ctl.adv    = adv;
  assign mix_ctl.active = s1_active_r;

  sedm_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix_l (
    .clk  (clk),
    .ctl  (mix_ctl),
    .gain (gain_eff),
    .cur  (cur_l_r),
    .past (past_l_r),
    .y    (y_l)
  );

  sedm_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix_r (
    .clk  (clk),
    .ctl  (mix_ctl),
    .gain (gain_eff),
    .cur  (cur_r_r),
    .past (past_r_r),
    .y    (y_r)
  );

  // User must keep config changes to idle, unchecked; mode stable for items in flight
  assign out_ch.left_out  = y_l;
  assign out_ch.right_out = stereo_r ? y_r : '0;

endmodule

[tb/stereo_echo_delay_mixer_tb.sv]
module stereo_echo_delay_mixer_tb;
  import sedm_pkg::*;

  localparam int MAX_DELAY   = 131072;
  localparam int SAMPLE_BITS = 16;
  // PIPE_LAT is the best-case accept to result handshake delay; SETTLE adds margin.
  localparam int PIPE_LAT    = 3;
  localparam int SETTLE      = PIPE_LAT + 4;
  // About 1020 items; the limit leaves room for the slowest idling phases.
  localparam int CYCLE_LIMIT = 200000;
  localparam longint GAIN_SCALE = longint'(1) << FRAC_BITS;
  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Keeps its own copy of the delay lines, pointers and registers, works out
  // the frame each accepted item should produce and checks what comes out.
  class echo_scoreboard;
    sample_t          left_hist [MAX_DELAY];
    sample_t          right_hist[MAX_DELAY];
    int unsigned      wr_ptr;
    int unsigned      fill_cnt;
    logic [DELAY_W-1:0] delay_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               stereo_reg;
    frame_t           expected_frames[$];
    int unsigned      errors;

    function new();
      wr_ptr     = 0;
      fill_cnt   = 0;
      delay_reg  = DELAY_RST;
      gain_reg   = GAIN_RST;
      stereo_reg = 1'b1;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DELAY:  delay_reg  = val[DELAY_W-1:0];
        REG_GAIN:   gain_reg   = val[GAIN_W-1:0];
        REG_STEREO: stereo_reg = val[0];
        default: ;
      endcase
    endfunction

    // dry + gain * tap, truncated toward zero, then clipped to the sample range
    function sample_t add_echo(sample_t dry, sample_t tap, int unsigned gain, bit on);
      longint hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
      longint lo = -hi - 1;
      longint acc;
      if (!on) return dry;
      acc = (longint'(dry) * GAIN_SCALE + longint'(gain) * longint'(tap)) / GAIN_SCALE;
      if (acc > hi) acc = hi;
      if (acc < lo) acc = lo;
      return sample_t'(acc);
    endfunction

    function void take_frame(sample_t l, sample_t r);
      int unsigned d = delay_reg;
      int unsigned g = gain_reg;
      int unsigned rd;
      bit          on;
      sample_t     xr;
      frame_t      y;
      if (d == 0) d = 1;
      if (d > MAX_DELAY) d = MAX_DELAY;
      if (g > GAIN_ONE) g = GAIN_ONE;
      // a lowered delay pulls the fill level down with it
      if (fill_cnt > d) fill_cnt = d;
      on = (fill_cnt >= d);
      rd = (wr_ptr >= d) ? wr_ptr - d : wr_ptr + MAX_DELAY - d;
      xr = stereo_reg ? r : '0;
      y.left  = add_echo(l, left_hist[rd], g, on);
      y.right = stereo_reg ? add_echo(xr, right_hist[rd], g, on) : '0;
      left_hist[wr_ptr]  = l;
      right_hist[wr_ptr] = xr;
      wr_ptr = (wr_ptr + 1 >= MAX_DELAY) ? 0 : wr_ptr + 1;
      if (fill_cnt < d) fill_cnt++;
      expected_frames = {expected_frames, y};
    endfunction

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    task check_frame(sample_t l, sample_t r);
      frame_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("frame (%0d, %0d) with nothing expected", l, r));
        return;
      end
      want = expected_frames.pop_front();
      if (l !== want.left)
        report($sformatf("left_out got %0d expected %0d", l, want.left));
      if (r !== want.right)
        report($sformatf("right_out got %0d expected %0d", r, want.right));
    endtask

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  idle_mode_t idle_mode = IDLE_NONE;
  int unsigned cycle_cnt = 0;
  echo_scoreboard sb = new();

  sedm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  sedm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_if ();
  sedm_cfg_if cfg_if ();

  stereo_echo_delay_mixer #(
    .MAX_DELAY  (MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if),
    .out_ch(out_if),
    .cfg_ch(cfg_if)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Sample every handshake at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) sb.take_frame(in_if.left_sample, in_if.right_sample);
      if (out_if.valid && out_if.ready) sb.check_frame(out_if.left_out, out_if.right_out);
    end
  end

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic bit sender_idle();
    case (idle_mode)
      IDLE_SENDER: return roll(81);
      IDLE_BOTH:   return roll(21);
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return roll(81);
      IDLE_BOTH:     return roll(21);
      default:       return 1'b0;
    endcase
  endfunction

  // Output side: ready toggles at the falling edge per the current idling phase.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= !receiver_stall();
    end
  end

  // Mostly full-range random, with the rails and near-zero values mixed in.
  function automatic sample_t pick_sample();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(4))
        0: return sample_t'(-32768);
        1: return sample_t'(32767);
        2: return sample_t'(0);
        3: return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  // Valid stays high on return so back-to-back items keep it high unless the sender idles.
  task automatic send_item(input sample_t l, input sample_t r);
    while (sender_idle()) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.left_sample  <= l;
    in_if.right_sample <= r;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding frame come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
  endtask

  // Registers only change with the pipeline empty.
  task automatic set_config(input int unsigned delay, input int unsigned gain,
                            input bit stereo, input bit poke_spare);
    drain();
    write_reg(REG_DELAY, CFG_DATA_W'(delay));
    write_reg(REG_GAIN, CFG_DATA_W'(gain));
    write_reg(REG_STEREO, CFG_DATA_W'(stereo));
    if (poke_spare) write_reg(REG_SPARE, '1);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input int n_items, input idle_mode_t mode, input int pause_at);
    idle_mode = mode;
    for (int i = 0; i < n_items; i++) begin
      // hold off until the block has emptied, mid-stream
      if (i == pause_at) begin
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        @(negedge clk);
      end
      send_item(pick_sample(), pick_sample());
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.left_sample  = '0;
    in_if.right_sample = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: zero delay acts as one, gain above one clips to one, spare index
    // is dropped. First frame passes through, then both rails saturate.
    set_config(0, 17'h1FFFF, 1'b1, 1'b1);
    send_item(32767, -32768);
    send_item(32767, -32768);
    send_item(-32768, 32767);
    send_item(-1, 1);
    send_item(0, 0);

    // Half gain: odd sums truncate toward zero on both signs.
    set_config(1, 32768, 1'b1, 1'b0);
    send_item(-1, 1);
    send_item(-1, 1);
    send_item(1, -1);
    send_item(-3, 3);

    // Mono with a raised delay: pass-through until three frames are held,
    // right input ignored and right out zero.
    set_config(3, GAIN_ONE, 1'b0, 1'b0);
    send_item(1000, 12345);
    send_item(-2000, -7);
    send_item(30000, 32767);
    send_item(5, -32768);
    send_item(30000, 1);

    // Lowered delay: fill level clips, echo on at once; right taps read the
    // zeros stored during mono.
    set_config(2, 65535, 1'b1, 1'b0);
    send_item(100, 200);
    send_item(-100, -200);
    send_item(7, 8);

    // Largest delay with zero gain: plain pass-through.
    set_config(131071, 0, 1'b1, 1'b0);
    send_item(-32768, 32767);
    send_item(1, -1);
    send_item(0, 0);

    // Random phases across delays, gains, modes and idling patterns.
    set_config(7, $urandom_range(65536), 1'b1, 1'b0);
    run_phase(140, IDLE_NONE, -1);
    set_config(1, GAIN_ONE, 1'b1, 1'b0);
    run_phase(140, IDLE_SENDER, -1);
    set_config(64, $urandom_range(65536), 1'b0, 1'b0);
    run_phase(140, IDLE_RECEIVER, -1);
    set_config(3, 17'h1FFFF, 1'b1, 1'b0);
    run_phase(140, IDLE_BOTH, 70);
    // raise from 3 to 200: long pass-through stretch, then echo resumes
    set_config(200, $urandom_range(65536), 1'b1, 1'b0);
    run_phase(260, IDLE_NONE, -1);
    set_config(131071, $urandom_range(65536), 1'b1, 1'b0);
    run_phase(40, IDLE_SENDER, -1);
    set_config(0, 40000, 1'b0, 1'b0);
    run_phase(140, IDLE_RECEIVER, -1);

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
